### sv/pss_pkg.sv
`timescale 1ns / 1ps

package pss_pkg;

    // Field widths fixed by the item formats
    localparam int SLOT_W = 4;
    localparam int ARR_W  = 16;
    localparam int BUR_W  = 16;
    localparam int URG_W  = 8;
    localparam int OUT_TW = 24;
    localparam int PC_W   = 5;

    // Item action codes
    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_TICK = 1'b1;

    typedef logic [OUT_TW-1:0] t_out_time;

    typedef struct packed {
        logic             action;
        logic [SLOT_W-1:0] slot;
        logic [ARR_W-1:0]  arrival_time;
        logic [BUR_W-1:0]  burst_time;
        logic [URG_W-1:0]  urgency;
    } t_item;

    typedef struct packed {
        logic [SLOT_W-1:0] chosen_slot;
        logic              idle;
        logic              finished;
        t_out_time         tick_time;
        t_out_time         completion_time;
        t_out_time         turnaround_time;
        t_out_time         waiting_time;
        t_out_time         response_time;
        logic              all_done;
    } t_result;

    // One task slot as held in the task memory
    typedef struct packed {
        logic [ARR_W-1:0] arrival;
        logic [BUR_W-1:0] burst;
        logic [URG_W-1:0] urgency;
        logic [BUR_W-1:0] remaining;
        t_out_time        response;
    } t_task_entry;

    // Sequencer controls for the scan unit
    typedef struct packed {
        logic clear;
        logic eval;
    } t_scan_ctrl;

endpackage

### sv/preemptive_priority_scheduler_unit.sv
`timescale 1ns / 1ps

// Preemptive priority scheduler. Pulse start with an item while busy is low:
// a load item writes one task slot, a tick item runs the most urgent ready
// task for one time unit. With n = min(process_count, MAX_TASKS), the time an
// item takes grows with n, and a new item is taken only once busy is low again;
// the time is set by the scan, which reads one task slot per cycle from the
// task memory (one write port, one registered read port) through one shared
// compare unit. Exactly one result per item appears on o_result for one cycle,
// marked by o_result_strobe; it is not held, so the receiver must take it in
// that cycle. The user must write configuration (process_count) with i_cfg_we
// only while busy is low; the block itself does not enforce this.
module preemptive_priority_scheduler_unit #(
    parameter int MAX_TASKS  = 16,
    parameter int TIME_WIDTH = 24
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  pss_pkg::t_item            i_item,
    output logic                      o_result_strobe,
    output pss_pkg::t_result          o_result,
    input  logic                      i_cfg_we,
    input  logic [pss_pkg::PC_W-1:0]  i_cfg_wdata
);
    import pss_pkg::*;

    localparam int IDX_W = $clog2(MAX_TASKS);
    localparam int CNT_W = $clog2(MAX_TASKS + 1);
    localparam int NW    = (CNT_W > PC_W) ? CNT_W : PC_W;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_LOAD = 5'b00010,
        ST_SCAN = 5'b00100,
        ST_UPD  = 5'b01000,
        ST_FIN  = 5'b10000
    } t_state;

    t_state                r_state, n_state;
    t_item                 r_item, n_item;
    logic [PC_W-1:0]       r_pc, n_pc;
    logic [TIME_WIDTH-1:0] r_elapsed, n_elapsed;
    logic [CNT_W-1:0]      r_cnt, n_cnt;
    logic                  r_vld, n_vld;
    logic [IDX_W-1:0]      r_vidx, n_vidx;
    logic                  r_run, n_run;
    logic                  r_all_before, n_all_before;
    t_task_entry           r_upd, n_upd;
    logic [TIME_WIDTH-1:0] r_diff, n_diff;
    logic                  r_strobe, n_strobe;
    t_result               r_result, n_result;

    logic [CNT_W-1:0]      active_n;
    logic [NW-1:0]         pc_ext;
    logic [NW-1:0]         max_ext;
    logic [TIME_WIDTH-1:0] elapsed_inc;

    logic                  mem_we;
    logic [IDX_W-1:0]      mem_waddr;
    t_task_entry           mem_wdata;
    t_task_entry           mem_rdata;

    t_scan_ctrl            scan_ctrl;
    logic                  scan_found;
    logic [IDX_W-1:0]      scan_best_idx;
    t_task_entry           scan_best;
    logic [CNT_W-1:0]      scan_done;

    logic                  accept;
    logic                  load_ok;
    logic                  fin_now;
    logic [CNT_W-1:0]      done_after;

    // Number of slots taking part
    always_comb begin
        pc_ext   = NW'(r_pc);
        max_ext  = NW'(MAX_TASKS);
        active_n = CNT_W'((pc_ext > max_ext) ? max_ext : pc_ext);
    end

    assign elapsed_inc = (r_elapsed == '1) ? r_elapsed : (r_elapsed + 1'b1);
    assign accept      = start && (r_state == ST_IDLE);
    assign load_ok     = (32'(r_item.slot) < MAX_TASKS);

    pss_task_mem #(
        .MAX_TASKS (MAX_TASKS)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (r_cnt[IDX_W-1:0]),
        .o_rdata (mem_rdata)
    );

    // Memory write: slot load, or write-back of the task that ran
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = scan_best_idx;
        mem_wdata = r_upd;
        if (r_state == ST_LOAD) begin
            mem_we    = load_ok;
            mem_waddr = IDX_W'(r_item.slot);
            mem_wdata.arrival   = r_item.arrival_time;
            mem_wdata.burst     = r_item.burst_time;
            mem_wdata.urgency   = r_item.urgency;
            mem_wdata.remaining = r_item.burst_time;
            mem_wdata.response  = '0;
        end else if (r_state == ST_FIN) begin
            mem_we = r_run;
        end
    end

    assign scan_ctrl.clear = accept;
    assign scan_ctrl.eval  = (r_state == ST_SCAN) && r_vld;

    pss_scan_unit #(
        .MAX_TASKS  (MAX_TASKS),
        .TIME_WIDTH (TIME_WIDTH)
    ) u_scan (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctrl     (scan_ctrl),
        .i_idx      (r_vidx),
        .i_entry    (mem_rdata),
        .i_elapsed  (r_elapsed),
        .o_found    (scan_found),
        .o_best_idx (scan_best_idx),
        .o_best     (scan_best),
        .o_done_cnt (scan_done)
    );

    assign fin_now    = r_run && (r_upd.remaining == '0);
    assign done_after = scan_done + CNT_W'(fin_now);

    // Sequencer
    always_comb begin
        n_state      = r_state;
        n_item       = r_item;
        n_pc         = r_pc;
        n_elapsed    = r_elapsed;
        n_cnt        = r_cnt;
        n_vld        = 1'b0;
        n_vidx       = r_vidx;
        n_run        = r_run;
        n_all_before = r_all_before;
        n_upd        = r_upd;
        n_diff       = r_diff;
        n_strobe     = 1'b0;
        n_result     = r_result;

        if (i_cfg_we) begin
            n_pc = i_cfg_wdata;
        end

        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_item  = i_item;
                    n_cnt   = '0;
                    n_state = (i_item.action == ACT_LOAD) ? ST_LOAD : ST_SCAN;
                end
            end
            ST_LOAD: begin
                n_state = ST_SCAN;
            end
            ST_SCAN: begin
                // Issue one read per cycle; the data is checked in the cycle after
                if (r_cnt < active_n) begin
                    n_vld  = 1'b1;
                    n_vidx = r_cnt[IDX_W-1:0];
                    n_cnt  = r_cnt + 1'b1;
                end else if (!r_vld) begin
                    n_state = ST_UPD;
                end
            end
            ST_UPD: begin
                n_all_before = (scan_done == active_n);
                n_run        = 1'b0;
                n_diff       = elapsed_inc - TIME_WIDTH'(scan_best.arrival);
                n_upd        = scan_best;
                n_upd.remaining = scan_best.remaining - 1'b1;
                if (scan_best.remaining == scan_best.burst) begin
                    n_upd.response = t_out_time'(n_diff);
                end
                if ((r_item.action == ACT_TICK) && (scan_done != active_n)) begin
                    n_elapsed = elapsed_inc;
                    n_run     = scan_found;
                end
                n_state = ST_FIN;
            end
            ST_FIN: begin
                n_result           = '0;
                n_result.tick_time = t_out_time'(r_elapsed);
                if (r_item.action == ACT_LOAD) begin
                    n_result.all_done = (scan_done == active_n);
                end else if (r_all_before) begin
                    n_result.idle     = 1'b1;
                    n_result.all_done = 1'b1;
                end else if (!r_run) begin
                    n_result.idle     = 1'b1;
                    n_result.all_done = (scan_done == active_n);
                end else begin
                    n_result.chosen_slot = SLOT_W'(scan_best_idx);
                    n_result.finished    = fin_now;
                    n_result.all_done    = (done_after == active_n);
                    if (fin_now) begin
                        n_result.completion_time = t_out_time'(r_elapsed);
                        n_result.turnaround_time = t_out_time'(r_diff);
                        n_result.response_time   = r_upd.response;
                        if (r_diff >= TIME_WIDTH'(r_upd.burst)) begin
                            n_result.waiting_time =
                                t_out_time'(r_diff - TIME_WIDTH'(r_upd.burst));
                        end
                    end
                end
                n_strobe = 1'b1;
                n_state  = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_pc      <= PC_W'(1);
            r_elapsed <= '0;
            r_cnt     <= '0;
            r_vld     <= 1'b0;
            r_run     <= 1'b0;
            r_strobe  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_pc      <= n_pc;
            r_elapsed <= n_elapsed;
            r_cnt     <= n_cnt;
            r_vld     <= n_vld;
            r_run     <= n_run;
            r_strobe  <= n_strobe;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_item       <= n_item;
        r_vidx       <= n_vidx;
        r_all_before <= n_all_before;
        r_upd        <= n_upd;
        r_diff       <= n_diff;
        r_result     <= n_result;
    end

    assign busy            = (r_state != ST_IDLE);
    assign o_result_strobe = r_strobe;
    assign o_result        = r_result;

endmodule

### sv/pss_task_mem.sv
`timescale 1ns / 1ps

module pss_task_mem #(
    parameter int MAX_TASKS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_we,
    input  logic [$clog2(MAX_TASKS)-1:0]  i_waddr,
    input  pss_pkg::t_task_entry          i_wdata,
    input  logic [$clog2(MAX_TASKS)-1:0]  i_raddr,
    output pss_pkg::t_task_entry          o_rdata
);
    import pss_pkg::*;

    t_task_entry r_mem [MAX_TASKS];
    t_task_entry r_rdata;

    // Single write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### sv/pss_scan_unit.sv
`timescale 1ns / 1ps

module pss_scan_unit #(
    parameter int MAX_TASKS  = 16,
    parameter int TIME_WIDTH = 24
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  pss_pkg::t_scan_ctrl             i_ctrl,
    input  logic [$clog2(MAX_TASKS)-1:0]    i_idx,
    input  pss_pkg::t_task_entry            i_entry,
    input  logic [TIME_WIDTH-1:0]           i_elapsed,
    output logic                            o_found,
    output logic [$clog2(MAX_TASKS)-1:0]    o_best_idx,
    output pss_pkg::t_task_entry            o_best,
    output logic [$clog2(MAX_TASKS+1)-1:0]  o_done_cnt
);
    import pss_pkg::*;

    localparam int IDX_W = $clog2(MAX_TASKS);
    localparam int CNT_W = $clog2(MAX_TASKS + 1);

    logic             r_found, n_found;
    logic [IDX_W-1:0] r_best_idx, n_best_idx;
    t_task_entry      r_best, n_best;
    logic [CNT_W-1:0] r_done, n_done;

    logic is_done;
    logic is_ready;
    logic is_better;

    // Shared compare: one slot per cycle against the running best
    always_comb begin
        is_done   = (i_entry.remaining == '0);
        is_ready  = !is_done && (TIME_WIDTH'(i_entry.arrival) <= i_elapsed);
        is_better = !r_found
                 || (i_entry.urgency < r_best.urgency)
                 || ((i_entry.urgency == r_best.urgency)
                     && (i_entry.arrival < r_best.arrival));
    end

    always_comb begin
        n_found    = r_found;
        n_best_idx = r_best_idx;
        n_best     = r_best;
        n_done     = r_done;
        if (i_ctrl.clear) begin
            n_found = 1'b0;
            n_done  = '0;
        end else if (i_ctrl.eval) begin
            if (is_done) begin
                n_done = r_done + 1'b1;
            end else if (is_ready && is_better) begin
                n_found    = 1'b1;
                n_best_idx = i_idx;
                n_best     = i_entry;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
            r_done  <= '0;
        end else begin
            r_found <= n_found;
            r_done  <= n_done;
        end
    end

    // Winner payload, no reset needed
    always_ff @(posedge i_clk) begin
        r_best_idx <= n_best_idx;
        r_best     <= n_best;
    end

    assign o_found    = r_found;
    assign o_best_idx = r_best_idx;
    assign o_best     = r_best;
    assign o_done_cnt = r_done;

endmodule

### sim/preemptive_priority_scheduler_unit_tb.sv
`timescale 1ns / 1ps

// Scoreboard for the scheduler: keeps its own copy of the task table, the clock
// of the schedule and the slot count, and works out the result of every transfer.
class sched_scoreboard;
    localparam int MAX_TASKS = 16;

    logic [pss_pkg::ARR_W-1:0]  arrival_mem [MAX_TASKS];
    logic [pss_pkg::BUR_W-1:0]  burst_mem   [MAX_TASKS];
    logic [pss_pkg::URG_W-1:0]  urgency_mem [MAX_TASKS];
    logic [pss_pkg::BUR_W-1:0]  left_mem    [MAX_TASKS];
    logic [pss_pkg::OUT_TW-1:0] resp_mem    [MAX_TASKS];
    logic [pss_pkg::OUT_TW-1:0] now_time;
    logic [pss_pkg::PC_W-1:0]   task_count;

    pss_pkg::t_result results_due [$];
    int mismatches;
    int results_seen;

    function new();
        now_time    = '0;
        task_count  = pss_pkg::PC_W'(1);
        mismatches  = 0;
        results_seen = 0;
    endfunction

    function int unsigned live_slots();
        return (task_count > MAX_TASKS) ? MAX_TASKS : task_count;
    endfunction

    function bit all_finished();
        int unsigned n;
        n = live_slots();
        for (int unsigned i = 0; i < n; i++) begin
            if (left_mem[i] != 0) return 1'b0;
        end
        return 1'b1;
    endfunction

    function void set_count(logic [pss_pkg::PC_W-1:0] value);
        task_count = value;
    endfunction

    // Accepted input: update the task table and queue the result it causes
    function void note_item(pss_pkg::t_item it);
        pss_pkg::t_result r;
        int unsigned n;
        int unsigned best;
        int unsigned tat;
        int unsigned wt;
        bit found;
        r = '0;
        if (it.action == pss_pkg::ACT_LOAD) begin
            arrival_mem[it.slot] = it.arrival_time;
            burst_mem[it.slot]   = it.burst_time;
            urgency_mem[it.slot] = it.urgency;
            left_mem[it.slot]    = it.burst_time;
            resp_mem[it.slot]    = '0;
            r.tick_time = now_time;
            r.all_done  = all_finished();
        end else if (all_finished()) begin
            r.idle      = 1'b1;
            r.tick_time = now_time;
            r.all_done  = 1'b1;
        end else begin
            n = live_slots();
            found = 1'b0;
            best = 0;
            // most urgent ready task; ties to earlier arrival, then lower slot
            for (int unsigned i = 0; i < n; i++) begin
                if (left_mem[i] == 0 || arrival_mem[i] > now_time) continue;
                if (!found || urgency_mem[i] < urgency_mem[best] ||
                    (urgency_mem[i] == urgency_mem[best] &&
                     arrival_mem[i] < arrival_mem[best])) begin
                    best = i;
                    found = 1'b1;
                end
            end
            if (now_time != '1) now_time = now_time + 1'b1;
            if (!found) begin
                r.idle = 1'b1;
            end else begin
                r.chosen_slot = best[pss_pkg::SLOT_W-1:0];
                if (left_mem[best] == burst_mem[best])
                    resp_mem[best] = now_time - arrival_mem[best];
                left_mem[best] = left_mem[best] - 1'b1;
                if (left_mem[best] == 0) begin
                    tat = now_time - arrival_mem[best];
                    wt  = (tat >= burst_mem[best]) ? tat - burst_mem[best] : 0;
                    r.finished        = 1'b1;
                    r.completion_time = now_time;
                    r.turnaround_time = tat[pss_pkg::OUT_TW-1:0];
                    r.waiting_time    = wt[pss_pkg::OUT_TW-1:0];
                    r.response_time   = resp_mem[best];
                end
            end
            r.tick_time = now_time;
            r.all_done  = all_finished();
        end
        results_due.push_back(r);
    endfunction

    function bit field_differs(string name, longint unsigned want, longint unsigned got);
        if (want == got) return 1'b0;
        mismatches++;
        if (mismatches <= 10)
            $display("result %0d: %s expected %0d, got %0d", results_seen, name, want, got);
        return 1'b1;
    endfunction

    // Accepted result: compare with the oldest pending one
    function void check_result(pss_pkg::t_result got);
        pss_pkg::t_result want;
        results_seen++;
        if (results_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("result %0d: strobe with nothing pending", results_seen);
            return;
        end
        want = results_due.pop_front();
        void'(field_differs("chosen_slot", want.chosen_slot, got.chosen_slot));
        void'(field_differs("idle", want.idle, got.idle));
        void'(field_differs("finished", want.finished, got.finished));
        void'(field_differs("tick_time", want.tick_time, got.tick_time));
        void'(field_differs("completion_time", want.completion_time,
                            got.completion_time));
        void'(field_differs("turnaround_time", want.turnaround_time,
                            got.turnaround_time));
        void'(field_differs("waiting_time", want.waiting_time, got.waiting_time));
        void'(field_differs("response_time", want.response_time, got.response_time));
        void'(field_differs("all_done", want.all_done, got.all_done));
    endfunction
endclass

module preemptive_priority_scheduler_unit_tb;
    import pss_pkg::*;

    localparam int ITEM_TARGET = 1500;
    localparam int CALM_TAIL   = 250;

    logic                i_clk;
    logic                i_rst_n;
    logic                start;
    logic                busy;
    t_item               i_item;
    logic                o_result_strobe;
    t_result             o_result;
    logic                i_cfg_we;
    logic [PC_W-1:0]     i_cfg_wdata;

    sched_scoreboard sb;
    int  items_sent;
    bit  allow_gaps;

    preemptive_priority_scheduler_unit #(
        .MAX_TASKS  (16),
        .TIME_WIDTH (24)
    ) u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_item          (i_item),
        .o_result_strobe (o_result_strobe),
        .o_result        (o_result),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata)
    );

    // 10 ns clock
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Sample both sides at the rising edge; result first, it belongs to an older item
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_result_strobe) sb.check_result(o_result);
            if (start && !busy) sb.note_item(i_item);
            if (i_cfg_we) sb.set_count(i_cfg_wdata);
        end
    end

    // Hold one item on the input until the block takes it; returns on a falling edge
    task automatic send_item(t_item it);
        bit taken;
        start  <= 1'b1;
        i_item <= it;
        taken = 1'b0;
        while (!taken) begin
            @(posedge i_clk);
            taken = !busy;
            @(negedge i_clk);
        end
        items_sent++;
    endtask

    // Random sender idling, placed either right after a transfer or after busy drops
    task automatic pace_sender();
        int pick;
        pick = $urandom_range(0, 5);
        if (!allow_gaps || pick > 1) return;
        start <= 1'b0;
        if (pick == 1) begin
            while (busy) @(negedge i_clk);
        end
        repeat ($urandom_range(1, 3)) @(negedge i_clk);
    endtask

    task automatic send_load(int unsigned slot, int unsigned arr, int unsigned bur,
                             int unsigned urg);
        t_item it;
        it = '0;
        it.action       = ACT_LOAD;
        it.slot         = slot[SLOT_W-1:0];
        it.arrival_time = arr[ARR_W-1:0];
        it.burst_time   = bur[BUR_W-1:0];
        it.urgency      = urg[URG_W-1:0];
        send_item(it);
        pace_sender();
    endtask

    task automatic send_tick();
        t_item it;
        logic [63:0] noise;
        // unused fields carry noise; the block must ignore them on a tick
        noise = {$urandom, $urandom};
        it = noise[$bits(t_item)-1:0];
        it.action = ACT_TICK;
        send_item(it);
        pace_sender();
    endtask

    // Stop sending and wait until every pending result has come and the block is idle
    task automatic drain();
        start <= 1'b0;
        while (sb.results_due.size() != 0 || busy) @(negedge i_clk);
        repeat (3) @(negedge i_clk);
    endtask

    task automatic write_task_count(int unsigned value);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value[PC_W-1:0];
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    function automatic int unsigned near_now(int unsigned spread);
        int unsigned a;
        a = sb.now_time + $urandom_range(0, spread);
        return (a > 16'hFFFF) ? 16'hFFFF : a;
    endfunction

    // Well-formed phase: load the live slots, then tick until everything is done
    task automatic run_schedule(int unsigned n);
        int unsigned ticks;
        int unsigned bur;
        int unsigned urg;
        for (int unsigned s = 0; s < n; s++) begin
            bur = ($urandom_range(0, 19) == 0) ? $urandom_range(6, 40) : $urandom_range(1, 5);
            urg = $urandom_range(0, 1) ? $urandom_range(0, 3) : $urandom_range(0, 255);
            send_load(s, near_now(12), bur, urg);
        end
        // a few loads aimed outside the live range; for n below 16 they must not take part
        repeat ($urandom_range(0, 2))
            send_load($urandom_range(0, 15) | n, $urandom_range(0, 65535),
                      $urandom_range(1, 65535), $urandom_range(0, 255));
        ticks = 0;
        while (!sb.all_finished() && ticks < 120) begin
            send_tick();
            ticks++;
            // late arrival that may preempt the running task
            if (n != 0 && $urandom_range(0, 14) == 0)
                send_load($urandom_range(0, n - 1), near_now(3), $urandom_range(1, 4),
                          $urandom_range(0, 255));
        end
        repeat ($urandom_range(0, 2)) send_tick();
    endtask

    // Noise phase: loose mix of loads and ticks with wide values
    task automatic run_noise();
        int unsigned arr;
        int unsigned bur;
        repeat ($urandom_range(10, 30)) begin
            if ($urandom_range(0, 1)) begin
                arr = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 65535) : near_now(20);
                bur = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 65535)
                                                  : $urandom_range(1, 4);
                send_load($urandom_range(0, 15), arr, bur, $urandom_range(0, 255));
            end else begin
                send_tick();
            end
        end
    endtask

    initial begin
        int unsigned pc;
        sb = new();
        items_sent  = 0;
        allow_gaps  = 1'b1;
        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_item      = '0;
        i_cfg_we    = 1'b0;
        i_cfg_wdata = '0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: one task with the reset slot count, run to completion and beyond
        send_load(0, 0, 2, 8'hFF);
        send_tick();
        send_tick();
        send_tick();
        // never arrives, lowest urgency number, longest burst
        send_load(1, 16'hFFFF, 16'hFFFF, 0);
        // same urgency and arrival: lower slot wins
        send_load(2, 2, 1, 0);
        send_load(3, 2, 1, 0);
        // earlier arrival beats the pair above
        send_load(4, 1, 2, 0);
        // zero burst counts as finished and never runs
        send_load(5, 0, 0, 0);
        for (int unsigned s = 6; s < 16; s++)
            send_load(s, s, 1, 255 - s);
        // no live slots: done at once
        write_task_count(0);
        send_tick();
        write_task_count(6);
        repeat (5) send_tick();

        // Random phases
        while (items_sent < ITEM_TARGET) begin
            case ($urandom_range(0, 9))
                0:       pc = 0;
                1:       pc = 1;
                2:       pc = 16;
                3:       pc = $urandom_range(17, 31);
                default: pc = $urandom_range(2, 15);
            endcase
            write_task_count(pc);
            allow_gaps = ($urandom_range(0, 3) != 0) && (items_sent < ITEM_TARGET - CALM_TAIL);
            if ($urandom_range(0, 9) < 8)
                run_schedule((pc > 16) ? 16 : pc);
            else
                run_noise();
        end

        drain();
        repeat (40) @(negedge i_clk);
        if (sb.mismatches == 0 && sb.results_due.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #5_000_000;
        $display("status: fail");
        $finish;
    end
endmodule
